>>> hdl/pixel_colour_key_modulate_blend_macros.svh
// Assertion macros shared by the checker of the pixel compositing unit
`ifndef PIXEL_COLOUR_KEY_MODULATE_BLEND_MACROS_SVH
`define PIXEL_COLOUR_KEY_MODULATE_BLEND_MACROS_SVH

// check a property outside reset
`define PCMB_ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check a property at every edge, reset included
`define PCMB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/pcmb_pkg.sv
// Types, codes and the rounded divide-by-255 product of the compositing unit
package pcmb_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_VALUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RED_MOD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MOD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MOD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MOD  = 3'd6;

  localparam logic [2:0] MODE_COPY = 3'd0;
  localparam logic [2:0] MODE_OVER = 3'd1;
  localparam logic [2:0] MODE_ADD  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_AMUL = 3'd4;

  localparam logic [7:0] FULL_SCALE = 8'd255;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [2:0]  blend_mode;
    logic        key_enable;
    logic [31:0] key_value;
    logic [7:0]  red_mod;
    logic [7:0]  green_mod;
    logic [7:0]  blue_mod;
    logic [7:0]  alpha_mod;
  } cfg_t;

  typedef struct packed {
    logic [31:0] src_raw;
    logic [7:0]  src_red;
    logic [7:0]  src_green;
    logic [7:0]  src_blue;
    logic [7:0]  src_alpha;
    logic [7:0]  dst_red;
    logic [7:0]  dst_green;
    logic [7:0]  dst_blue;
    logic [7:0]  dst_alpha;
  } pix_in_t;

  typedef struct packed {
    logic       write_enable;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_out_t;

  typedef struct packed {
    logic            key_hit;
    logic [2:0][7:0] s;
    logic [7:0]      sa;
    logic [2:0][7:0] d;
    logic [7:0]      da;
  } mod_t;

  typedef struct packed {
    logic            key_hit;
    logic [2:0][7:0] s;
    logic [7:0]      sa;
    logic [2:0][7:0] d;
    logic [7:0]      da;
    logic [2:0][7:0] ss;
    logic [2:0][7:0] dinv;
    logic [2:0][7:0] sd;
    logic [7:0]      dainv;
  } prod_t;

  function automatic logic [7:0] mul255(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] t;
    logic [15:0] u;
    t = 16'(a) * 16'(b) + 16'd128;
    u = t + (t >> 8);
    return u[15:8];
  endfunction

endpackage

>>> hdl/pcmb_stream_if.sv
// Valid/ready channel carrying one word of a given payload type
interface pcmb_stream_if #(parameter type word_t = logic);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/pcmb_cfg_regs.sv
// Configuration register file of the compositing unit
module pcmb_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  pcmb_stream_if.sink   cfg_ch,
  output pcmb_pkg::cfg_t cfg
);
  import pcmb_pkg::*;

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blend_mode <= MODE_COPY;
      cfg_r.key_enable <= 1'b0;
      cfg_r.key_value  <= 32'd0;
      cfg_r.red_mod    <= FULL_SCALE;
      cfg_r.green_mod  <= FULL_SCALE;
      cfg_r.blue_mod   <= FULL_SCALE;
      cfg_r.alpha_mod  <= FULL_SCALE;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_BLEND_MODE: cfg_r.blend_mode <= cfg_ch.data.value[2:0];
        REG_KEY_ENABLE: cfg_r.key_enable <= cfg_ch.data.value[0];
        REG_KEY_VALUE:  cfg_r.key_value  <= cfg_ch.data.value[31:0];
        REG_RED_MOD:    cfg_r.red_mod    <= cfg_ch.data.value[7:0];
        REG_GREEN_MOD:  cfg_r.green_mod  <= cfg_ch.data.value[7:0];
        REG_BLUE_MOD:   cfg_r.blue_mod   <= cfg_ch.data.value[7:0];
        REG_ALPHA_MOD:  cfg_r.alpha_mod  <= cfg_ch.data.value[7:0];
        default: begin
        end
      endcase
    end
  end
endmodule

>>> hdl/pcmb_modulate.sv
// First stage: colour key compare and source modulation
module pcmb_modulate (
  input  logic              clk,
  input  logic              rst_n,
  input  pcmb_pkg::cfg_t    cfg,
  input  logic              up_valid,
  input  pcmb_pkg::pix_in_t up_data,
  output logic              up_ready,
  output logic              dn_valid,
  output pcmb_pkg::mod_t    dn_data,
  input  logic              dn_ready
);
  import pcmb_pkg::*;

  logic valid_r;
  mod_t data_r;
  mod_t data_nxt;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt.key_hit = cfg.key_enable && (up_data.src_raw == cfg.key_value);
    data_nxt.s[0]    = mul255(up_data.src_red, cfg.red_mod);
    data_nxt.s[1]    = mul255(up_data.src_green, cfg.green_mod);
    data_nxt.s[2]    = mul255(up_data.src_blue, cfg.blue_mod);
    data_nxt.sa      = mul255(up_data.src_alpha, cfg.alpha_mod);
    data_nxt.d[0]    = up_data.dst_red;
    data_nxt.d[1]    = up_data.dst_green;
    data_nxt.d[2]    = up_data.dst_blue;
    data_nxt.da      = up_data.dst_alpha;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end
endmodule

>>> hdl/pcmb_blend_mul.sv
// Second stage: blend products of source, destination and alpha
module pcmb_blend_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  input  pcmb_pkg::mod_t  up_data,
  output logic            up_ready,
  output logic            dn_valid,
  output pcmb_pkg::prod_t dn_data,
  input  logic            dn_ready
);
  import pcmb_pkg::*;

  logic       valid_r;
  prod_t      data_r;
  prod_t      data_nxt;
  logic [7:0] inv;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;
  assign inv      = FULL_SCALE - up_data.sa;

  always_comb begin
    data_nxt.key_hit = up_data.key_hit;
    data_nxt.s       = up_data.s;
    data_nxt.sa      = up_data.sa;
    data_nxt.d       = up_data.d;
    data_nxt.da      = up_data.da;
    for (int i = 0; i < 3; i++) begin
      data_nxt.ss[i]   = mul255(up_data.s[i], up_data.sa);
      data_nxt.dinv[i] = mul255(up_data.d[i], inv);
      data_nxt.sd[i]   = mul255(up_data.s[i], up_data.d[i]);
    end
    data_nxt.dainv = mul255(up_data.da, inv);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end
endmodule

>>> hdl/pcmb_combine.sv
// Third stage: mode select, final sums and the output register
module pcmb_combine (
  input  logic               clk,
  input  logic               rst_n,
  input  pcmb_pkg::cfg_t     cfg,
  input  logic               up_valid,
  input  pcmb_pkg::prod_t    up_data,
  output logic               up_ready,
  output logic               dn_valid,
  output pcmb_pkg::pix_out_t dn_data,
  input  logic               dn_ready
);
  import pcmb_pkg::*;

  logic            valid_r;
  pix_out_t        data_r;
  pix_out_t        data_nxt;
  logic [2:0][7:0] colour;
  logic [7:0]      alpha;
  logic [8:0]      sat_sum;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    colour  = up_data.s;
    alpha   = up_data.sa;
    sat_sum = 9'd0;
    case (cfg.blend_mode)
      MODE_COPY: begin
        colour = up_data.s;
        alpha  = up_data.sa;
      end
      MODE_OVER: begin
        for (int i = 0; i < 3; i++) begin
          colour[i] = up_data.ss[i] + up_data.dinv[i];
        end
        alpha = up_data.sa + up_data.dainv;
      end
      MODE_ADD: begin
        for (int i = 0; i < 3; i++) begin
          sat_sum   = {1'b0, up_data.ss[i]} + {1'b0, up_data.d[i]};
          colour[i] = sat_sum[8] ? FULL_SCALE : sat_sum[7:0];
        end
        alpha = up_data.da;
      end
      MODE_MUL: begin
        colour = up_data.sd;
        alpha  = up_data.da;
      end
      MODE_AMUL: begin
        for (int i = 0; i < 3; i++) begin
          colour[i] = mul255(up_data.sd[i], up_data.sa) + up_data.dinv[i];
        end
        alpha = up_data.da;
      end
      default: begin
        colour = up_data.s;
        alpha  = up_data.sa;
      end
    endcase

    if (up_data.key_hit) begin
      data_nxt = '0;
    end else begin
      data_nxt.write_enable = 1'b1;
      data_nxt.out_red      = colour[0];
      data_nxt.out_green    = colour[1];
      data_nxt.out_blue     = colour[2];
      data_nxt.out_alpha    = alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data_r <= data_nxt;
    end
  end
endmodule

>>> hdl/pixel_colour_key_modulate_blend.sv
// Pixel compositing unit: colour key, source modulation and blend modes
//
// Takes one pixel word per clock and returns one result word per clock while
// the output is not stalled. The three register stages are set by the chain
// of rounded divide-by-255 products: modulation, the blend products, then the
// alpha-weighted product with the final sums and selection in front of the
// output register. A stall at the output holds every stage in place; bubbles
// in the pipeline still fill while the output waits. The configuration port
// is always ready and takes effect at once, so write it only while no pixel
// is in flight.
module pixel_colour_key_modulate_blend (
  input  logic          clk,
  input  logic          rst_n,
  pcmb_stream_if.sink   in_ch,
  pcmb_stream_if.source out_ch,
  pcmb_stream_if.sink   cfg_ch
);
  import pcmb_pkg::*;

  cfg_t     cfg;
  logic     mod_valid;
  logic     mod_ready;
  mod_t     mod_data;
  logic     prod_valid;
  logic     prod_ready;
  prod_t    prod_data;
  pix_out_t res_data;

  pcmb_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  pcmb_modulate u_modulate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_ch.valid),
    .up_data  (in_ch.data),
    .up_ready (in_ch.ready),
    .dn_valid (mod_valid),
    .dn_data  (mod_data),
    .dn_ready (mod_ready)
  );

  pcmb_blend_mul u_blend_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (mod_valid),
    .up_data  (mod_data),
    .up_ready (mod_ready),
    .dn_valid (prod_valid),
    .dn_data  (prod_data),
    .dn_ready (prod_ready)
  );

  pcmb_combine u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (prod_valid),
    .up_data  (prod_data),
    .up_ready (prod_ready),
    .dn_valid (out_ch.valid),
    .dn_data  (res_data),
    .dn_ready (out_ch.ready)
  );

  assign out_ch.data = res_data;
endmodule

>>> hdl/pcmb_checker.sv
// Port-level checks of the compositing unit and their binding
`include "pixel_colour_key_modulate_blend_macros.svh"

module pcmb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input pcmb_pkg::pix_out_t out_data
);
  import pcmb_pkg::*;

  `PCMB_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "output valid after reset")
  `PCMB_ASSERT_ON(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled word changed")
  `PCMB_ASSERT_ON(a_keyed_zero, clk, rst_n, out_valid && !out_data.write_enable |-> out_data.out_red == 8'd0 && out_data.out_green == 8'd0 && out_data.out_blue == 8'd0 && out_data.out_alpha == 8'd0, "keyed word not cleared")
  `PCMB_ASSERT_ON(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")
  `PCMB_ASSERT_ON(a_latency, clk, rst_n, in_valid && in_ready ##1 out_ready ##1 out_ready |=> out_valid, "word lost in pipeline")
endmodule

bind pixel_colour_key_modulate_blend pcmb_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

>>> dv/tb_pixel_colour_key_modulate_blend.sv
// Testbench for the pixel compositing unit: directed and random pixels against a predictor
module tb_pixel_colour_key_modulate_blend;
  import pcmb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst_n;

  pcmb_stream_if #(.word_t(pix_in_t))  in_ch ();
  pcmb_stream_if #(.word_t(pix_out_t)) out_ch ();
  pcmb_stream_if #(.word_t(cfg_wr_t))  cfg_ch ();

  pixel_colour_key_modulate_blend u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  cfg_t     cur_cfg;
  pix_out_t pending_pixels[$];
  int       error_count = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 0;
  int       sink_stall_pct = 0;

  always #5 clk = ~clk;

  function automatic logic [7:0] scale_div255(input logic [7:0] x, input logic [7:0] f);
    int unsigned t;
    t = x * f + 128;
    return 8'((t + (t >> 8)) >> 8);
  endfunction

  function automatic pix_out_t composite_pixel(input pix_in_t p, input cfg_t c);
    logic [7:0]  s[3];
    logic [7:0]  d[3];
    logic [7:0]  o[3];
    logic [7:0]  sa;
    logic [7:0]  inv;
    logic [7:0]  oa;
    int unsigned sum;
    pix_out_t    r;
    if (c.key_enable && p.src_raw == c.key_value) begin
      return '0;
    end
    s[0] = scale_div255(p.src_red, c.red_mod);
    s[1] = scale_div255(p.src_green, c.green_mod);
    s[2] = scale_div255(p.src_blue, c.blue_mod);
    sa   = scale_div255(p.src_alpha, c.alpha_mod);
    d[0] = p.dst_red;
    d[1] = p.dst_green;
    d[2] = p.dst_blue;
    inv  = FULL_SCALE - sa;
    o    = s;
    oa   = sa;
    case (c.blend_mode)
      MODE_OVER: begin
        for (int i = 0; i < 3; i++) o[i] = scale_div255(s[i], sa) + scale_div255(d[i], inv);
        oa = sa + scale_div255(p.dst_alpha, inv);
      end
      MODE_ADD: begin
        for (int i = 0; i < 3; i++) begin
          sum  = scale_div255(s[i], sa) + d[i];
          o[i] = (sum > FULL_SCALE) ? FULL_SCALE : 8'(sum);
        end
        oa = p.dst_alpha;
      end
      MODE_MUL: begin
        for (int i = 0; i < 3; i++) o[i] = scale_div255(s[i], d[i]);
        oa = p.dst_alpha;
      end
      MODE_AMUL: begin
        for (int i = 0; i < 3; i++)
          o[i] = scale_div255(scale_div255(s[i], d[i]), sa) + scale_div255(d[i], inv);
        oa = p.dst_alpha;
      end
      default: ;
    endcase
    r.write_enable = 1'b1;
    r.out_red      = o[0];
    r.out_green    = o[1];
    r.out_blue     = o[2];
    r.out_alpha    = oa;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    pix_out_t got;
    pix_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (pending_pixels.size() == 0) begin
        report_mismatch("unexpected word", got, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (got.write_enable !== want.write_enable)
          report_mismatch("write_enable", got.write_enable, want.write_enable);
        if (got.out_red !== want.out_red) report_mismatch("out_red", got.out_red, want.out_red);
        if (got.out_green !== want.out_green)
          report_mismatch("out_green", got.out_green, want.out_green);
        if (got.out_blue !== want.out_blue)
          report_mismatch("out_blue", got.out_blue, want.out_blue);
        if (got.out_alpha !== want.out_alpha)
          report_mismatch("out_alpha", got.out_alpha, want.out_alpha);
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.data.index = idx;
    cfg_ch.data.value = value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_BLEND_MODE: cur_cfg.blend_mode = value[2:0];
      REG_KEY_ENABLE: cur_cfg.key_enable = value[0];
      REG_KEY_VALUE:  cur_cfg.key_value  = value;
      REG_RED_MOD:    cur_cfg.red_mod    = value[7:0];
      REG_GREEN_MOD:  cur_cfg.green_mod  = value[7:0];
      REG_BLUE_MOD:   cur_cfg.blue_mod   = value[7:0];
      REG_ALPHA_MOD:  cur_cfg.alpha_mod  = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_pixel(input pix_in_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.data  = p;
    do @(posedge clk); while (!in_ch.ready);
    pending_pixels.push_back(composite_pixel(p, cur_cfg));
  endtask

  task automatic wait_pipeline_empty();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
  endtask

  function automatic pix_in_t make_pixel(input logic [31:0] raw, input logic [7:0] sr,
                                         input logic [7:0] sg, input logic [7:0] sb,
                                         input logic [7:0] sa, input logic [7:0] dr,
                                         input logic [7:0] dg, input logic [7:0] db,
                                         input logic [7:0] da);
    pix_in_t p;
    p.src_raw   = raw;
    p.src_red   = sr;
    p.src_green = sg;
    p.src_blue  = sb;
    p.src_alpha = sa;
    p.dst_red   = dr;
    p.dst_green = dg;
    p.dst_blue  = db;
    p.dst_alpha = da;
    return p;
  endfunction

  function automatic logic [7:0] rand_comp();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pix_in_t random_pixel();
    pix_in_t p;
    p = make_pixel($urandom, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), rand_comp(), rand_comp());
    if (cur_cfg.key_enable) begin
      case ($urandom_range(0, 5))
        0: p.src_raw = cur_cfg.key_value;
        1: p.src_raw = cur_cfg.key_value ^ (32'd1 << $urandom_range(0, 31));
        default: ;
      endcase
    end
    return p;
  endfunction

  task automatic randomise_regs();
    write_reg(REG_BLEND_MODE, $urandom_range(0, 7));
    write_reg(REG_KEY_ENABLE, $urandom_range(0, 1));
    write_reg(REG_KEY_VALUE, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
    write_reg(REG_RED_MOD, rand_comp());
    write_reg(REG_GREEN_MOD, rand_comp());
    write_reg(REG_BLUE_MOD, rand_comp());
    write_reg(REG_ALPHA_MOD, rand_comp());
  endtask

  task automatic test_reset_values();
    send_pixel(make_pixel(32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_pixel(make_pixel(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                          8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_pixel(make_pixel(32'h1234_5678, 8'h80, 8'h7F, 8'h01, 8'hFE,
                          8'h55, 8'hAA, 8'h33, 8'hCC));
  endtask

  task automatic test_blend_modes();
    wait_pipeline_empty();
    write_reg(REG_ALPHA_MOD, 8'hC0);
    write_reg(REG_RED_MOD, 8'h00);
    for (int m = 0; m < 2 ** $bits(cur_cfg.blend_mode); m++) begin
      wait_pipeline_empty();
      write_reg(REG_BLEND_MODE, m);
      send_pixel(make_pixel(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hF0, 8'hFF,
                            8'h00, 8'hC8, 8'hFF, 8'h00));
      send_pixel(make_pixel(32'h0, 8'h00, 8'h9C, 8'hFF, 8'h40,
                            8'hFF, 8'h80, 8'hFF, 8'hFF));
    end
    wait_pipeline_empty();
    write_reg(REG_ALPHA_MOD, FULL_SCALE);
    write_reg(REG_RED_MOD, FULL_SCALE);
  endtask

  task automatic test_colour_key();
    wait_pipeline_empty();
    write_reg(REG_BLEND_MODE, MODE_OVER);
    write_reg(REG_KEY_ENABLE, 1'b1);
    write_reg(REG_KEY_VALUE, 32'hA5A5_5AC3);
    send_pixel(make_pixel(32'hA5A5_5AC3, 8'hFF, 8'h10, 8'h20, 8'h80,
                          8'h01, 8'h02, 8'h03, 8'h04));
    send_pixel(make_pixel(32'hA5A5_5AC2, 8'hFF, 8'h10, 8'h20, 8'h80,
                          8'h01, 8'h02, 8'h03, 8'h04));
    wait_pipeline_empty();
    write_reg(REG_KEY_VALUE, 32'hFFFF_FFFF);
    send_pixel(make_pixel(32'hFFFF_FFFF, 8'h11, 8'h22, 8'h33, 8'h44,
                          8'h55, 8'h66, 8'h77, 8'h88));
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    sent           = 0;
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    while (sent < n_items) begin
      wait_pipeline_empty();
      randomise_regs();
      repeat ($urandom_range(20, 50)) begin
        send_pixel(random_pixel());
        sent++;
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
    cur_cfg.blend_mode = MODE_COPY;
    cur_cfg.key_enable = 1'b0;
    cur_cfg.key_value  = '0;
    cur_cfg.red_mod    = FULL_SCALE;
    cur_cfg.green_mod  = FULL_SCALE;
    cur_cfg.blue_mod   = FULL_SCALE;
    cur_cfg.alpha_mod  = FULL_SCALE;
    send_idle_pct  = 27;
    sink_stall_pct = 55;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    test_reset_values();
    test_blend_modes();
    test_colour_key();
    test_random_traffic(160, 27, 55);
    test_random_traffic(160, 55, 27);
    test_random_traffic(160, 0, 0);

    wait_pipeline_empty();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
